// ===== design/doad_pkg.sv =====
// ----------------------------------------------------------------------------
// DER OID arc decoder package
// Shared constants, status codes and the result record of the arc decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package doad_pkg;

   localparam int ARC_BITS_DEFAULT = 32;
   localparam int ARC_OUT_BITS     = 32;
   localparam int GROUP_BITS       = 7;

   localparam logic [7:0] CONT_MARK  = 8'h80;
   localparam logic [7:0] GROUP_MASK = 8'h7F;

   // The first sub-identifier is split by 40 = 8 * 5. The running remainder
   // stays below 40, so one step divides a 13-bit value: shift by three, then
   // divide by five through x * 205 >> 10, which is exact for x below 1024.
   localparam int FIRST_DIVISOR = 40;
   localparam int REM_BITS      = 6;
   localparam int STEP_BITS     = REM_BITS + GROUP_BITS;
   localparam int DIV5_IN_BITS  = STEP_BITS - 3;
   localparam int DIV5_RECIP    = 205;
   localparam int DIV5_SHIFT    = 10;
   localparam int STEP_Q_BITS   = 8;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   typedef struct packed {
      logic [ARC_OUT_BITS-1:0] arc_value;
      logic                    last_arc;
      logic [1:0]              status;
   } result_type;

endpackage

`default_nettype wire

// ===== design/der_oid_arc_decoder.sv =====
// A result enters the registered output queue when its content byte is accepted.
// Throughput: one byte per cycle while the result side keeps up; a byte that
// ends the first sub-identifier gives two results, which leave the queue in turn.
// req_tready is high while at most one result waits in the three-entry output queue.
// Reset (synchronous, active high) empties the queue and clears the
// sub-identifier state, so the next byte starts a first sub-identifier.
// ----------------------------------------------------------------------------
// DER OID arc decoder
// Turns a stream of OID content bytes into arc numbers, flagging overflow and
// content that ends inside a sub-identifier.
// ----------------------------------------------------------------------------
`default_nettype none

module der_oid_arc_decoder
   import doad_pkg::*;
#(
   parameter int ARC_BITS = ARC_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [7:0]              req_tdata,  // [7:0] content_byte
   input  wire logic                    req_tlast,  // end_of_content
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [ARC_OUT_BITS-1:0]      rsp_tdata,  // [31:0] arc_value
   output logic                         rsp_tlast,  // last_arc
   output logic [1:0]                   rsp_tuser   // [1:0] status
);

   localparam int QDEPTH = 3;

   logic [ARC_BITS-1:0]     acc_ff, acc_in;
   logic [ARC_BITS-1:0]     quo_ff, quo_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic                    first_ff, first_in;
   logic                    ovf_ff, ovf_in;
   result_type              slot_ff [QDEPTH];
   result_type              slot_in [QDEPTH];
   logic [1:0]              count_ff, count_in;

   logic                    accept;
   logic                    pop;
   logic [GROUP_BITS-1:0]   group;
   logic                    cont;
   logic                    ovf_now;
   logic [ARC_BITS-1:0]     acc_next;
   logic [STEP_BITS-1:0]    step_val;
   logic [DIV5_IN_BITS+7:0] div_prod;
   logic [STEP_Q_BITS-1:0]  step_q;
   logic [STEP_BITS-1:0]    step_r;
   logic [ARC_BITS-1:0]     quo_next;
   logic [ARC_OUT_BITS-1:0] sat_arc;
   result_type              res0, res1;
   logic [1:0]              push_n;
   logic [1:0]              count_mid;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign group  = req_tdata[GROUP_BITS-1:0];
   assign cont   = (req_tdata & CONT_MARK) != 8'd0;

   // Set bits about to leave the accumulator mark the sub-identifier as overflowed.
   assign ovf_now  = ovf_ff || (acc_ff[ARC_BITS-1 -: GROUP_BITS] != '0);
   assign acc_next = {acc_ff[ARC_BITS-GROUP_BITS-1:0], group};

   // The quotient and remainder by 40 are kept alongside the accumulator:
   // 128 * (40q + r) + g = 40 * (128q + (128r + g) / 40) + (128r + g) % 40.
   assign step_val = {rem_ff, group};
   assign div_prod = step_val[STEP_BITS-1:3] * (DIV5_IN_BITS+8)'(DIV5_RECIP);
   assign step_q   = div_prod[DIV5_SHIFT +: STEP_Q_BITS];
   assign step_r   = step_val - STEP_BITS'(step_q) * STEP_BITS'(FIRST_DIVISOR);
   assign quo_next = {quo_ff[ARC_BITS-GROUP_BITS-1:0], {GROUP_BITS{1'b0}}}
                     + ARC_BITS'(step_q);
   assign sat_arc  = ARC_OUT_BITS'({ARC_BITS{1'b1}});

   always_comb begin
      res0   = '{arc_value: '0, last_arc: 1'b1, status: STATUS_TRUNCATED};
      res1   = res0;
      push_n = 2'd0;
      if (accept) begin
         if (cont) begin
            if (req_tlast) begin
               push_n = 2'd1;
            end
         end else if (first_ff) begin
            push_n = 2'd2;
            if (ovf_now) begin
               res0 = '{arc_value: sat_arc, last_arc: 1'b0, status: STATUS_OVERFLOW};
               res1 = '{arc_value: sat_arc, last_arc: req_tlast, status: STATUS_OVERFLOW};
            end else begin
               res0 = '{arc_value: ARC_OUT_BITS'(quo_next), last_arc: 1'b0,
                        status: STATUS_OK};
               res1 = '{arc_value: ARC_OUT_BITS'(step_r[REM_BITS-1:0]),
                        last_arc: req_tlast, status: STATUS_OK};
            end
         end else begin
            push_n = 2'd1;
            if (ovf_now) begin
               res0 = '{arc_value: sat_arc, last_arc: req_tlast, status: STATUS_OVERFLOW};
            end else begin
               res0 = '{arc_value: ARC_OUT_BITS'(acc_next), last_arc: req_tlast,
                        status: STATUS_OK};
            end
         end
      end
   end

   // Sub-identifier state.
   always_comb begin
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      first_in = first_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (cont && !req_tlast) begin
            acc_in = acc_next;
            quo_in = quo_next;
            rem_in = step_r[REM_BITS-1:0];
            ovf_in = ovf_now;
         end else begin
            acc_in   = '0;
            quo_in   = '0;
            rem_in   = '0;
            ovf_in   = 1'b0;
            first_in = req_tlast ? 1'b1 : 1'b0;
         end
      end
   end

   // Output queue: slot 0 is the head, entries shift down on each accepted result.
   assign count_mid = count_ff - {1'b0, pop};
   assign count_in  = count_mid + push_n;

   always_comb begin
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && (i < QDEPTH - 1)) begin
            slot_in[i] = slot_ff[i+1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((push_n != 2'd0) && (2'(i) == count_mid)) begin
            slot_in[i] = res0;
         end else if ((push_n == 2'd2) && (2'(i) == count_mid + 2'd1)) begin
            slot_in[i] = res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         quo_ff   <= '0;
         rem_ff   <= '0;
         first_ff <= 1'b1;
         ovf_ff   <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         acc_ff   <= acc_in;
         quo_ff   <= quo_in;
         rem_ff   <= rem_in;
         first_ff <= first_in;
         ovf_ff   <= ovf_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign req_tready = count_ff <= 2'd1;
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = slot_ff[0].arc_value;
   assign rsp_tlast  = slot_ff[0].last_arc;
   assign rsp_tuser  = slot_ff[0].status;

endmodule

`default_nettype wire

// ===== design/doad_checker.sv =====
// ----------------------------------------------------------------------------
// DER OID arc decoder checker
// Port-level properties of the arc decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module doad_checker
   import doad_pkg::*;
#(
   parameter int ARC_BITS = ARC_BITS_DEFAULT
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_tvalid,
   input wire logic                    req_tready,
   input wire logic [7:0]              req_tdata,
   input wire logic                    req_tlast,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [ARC_OUT_BITS-1:0] rsp_tdata,
   input wire logic                    rsp_tlast,
   input wire logic [1:0]              rsp_tuser
);

   localparam logic [ARC_OUT_BITS-1:0] SAT_ARC = ARC_OUT_BITS'({ARC_BITS{1'b1}});

   // No result may come out of reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A byte that closes a sub-identifier or the identifier leaves a result
   // valid on the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (((req_tdata & CONT_MARK) == 8'd0) || req_tlast))
         |=> rsp_tvalid)
      else $error("completed sub-identifier gave no result");

   // A truncated identifier reports a zero arc and closes the identifier.
   a_truncated_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_TRUNCATED)) |-> ((rsp_tdata == '0) && rsp_tlast))
      else $error("truncation result malformed");

   // An overflowed arc is always saturated.
   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_OVERFLOW)) |-> (rsp_tdata == SAT_ARC))
      else $error("overflow arc not saturated");

   // A stalled result holds its payload.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind der_oid_arc_decoder doad_checker #(.ARC_BITS(ARC_BITS)) u_doad_checker (.*);

`default_nettype wire

// ===== sim/der_oid_arc_checker.sv =====
// ----------------------------------------------------------------------------
// DER OID arc decoder checker
// Watches the content-byte and result streams of the arc decoder. It decodes
// every accepted byte into the arcs it should produce and compares each
// accepted result with the oldest arc still outstanding.
// ----------------------------------------------------------------------------
module der_oid_arc_checker
   import doad_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic [7:0]              req_tdata,   // [7:0] content_byte
   input  wire logic                    req_tlast,   // end_of_content
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [ARC_OUT_BITS-1:0] rsp_tdata,   // [31:0] arc_value
   input  wire logic                    rsp_tlast,   // last_arc
   input  wire logic [1:0]              rsp_tuser,   // [1:0] status
   output int                           error_count,
   output int                           pending_arcs
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ACC_BITS = ARC_BITS_DEFAULT;

   logic [ACC_BITS-1:0] arc_accum;
   logic                first_subid;
   logic                subid_overflow;
   result_type          expected_arcs[$];

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic push_arc(input logic [ARC_OUT_BITS-1:0] value, input logic last,
                           input logic [1:0] status);
      result_type arc;
      arc.arc_value = value;
      arc.last_arc  = last;
      arc.status    = status;
      expected_arcs.push_back(arc);
   endtask

   task automatic clear_identifier();
      arc_accum      = '0;
      first_subid    = 1'b1;
      subid_overflow = 1'b0;
   endtask

   // Folds one content byte into the running sub-identifier and queues the
   // arcs that a completed sub-identifier yields.
   task automatic decode_byte(input logic [7:0] content, input logic eoc);
      logic [ACC_BITS-1:0] quotient;
      logic [ACC_BITS-1:0] remainder;
      logic [1:0]          status;
      if ((arc_accum >> (ACC_BITS - GROUP_BITS)) != 0)
         subid_overflow = 1'b1;
      arc_accum = (arc_accum << GROUP_BITS) | ACC_BITS'(content & GROUP_MASK);
      status = subid_overflow ? STATUS_OVERFLOW : STATUS_OK;
      if ((content & CONT_MARK) != 0) begin
         // The identifier ended inside a sub-identifier.
         if (eoc) begin
            push_arc('0, 1'b1, STATUS_TRUNCATED);
            clear_identifier();
         end
      end else begin
         if (first_subid) begin
            if (subid_overflow) begin
               push_arc('1, 1'b0, status);
               push_arc('1, eoc, status);
            end else begin
               quotient  = arc_accum / FIRST_DIVISOR;
               remainder = arc_accum % FIRST_DIVISOR;
               push_arc(quotient[ARC_OUT_BITS-1:0], 1'b0, status);
               push_arc(remainder[ARC_OUT_BITS-1:0], eoc, status);
            end
            first_subid = 1'b0;
         end else begin
            if (subid_overflow)
               push_arc('1, eoc, status);
            else
               push_arc(arc_accum[ARC_OUT_BITS-1:0], eoc, status);
         end
         arc_accum      = '0;
         subid_overflow = 1'b0;
         if (eoc)
            clear_identifier();
      end
   endtask

   task automatic check_arc();
      result_type want;
      if (expected_arcs.size() == 0) begin
         report($sformatf("unexpected result arc %0d last %0b status %0d",
                          rsp_tdata, rsp_tlast, rsp_tuser));
      end else begin
         want = expected_arcs.pop_front();
         if (rsp_tdata !== want.arc_value)
            report($sformatf("arc_value %0d, expected %0d", rsp_tdata, want.arc_value));
         if (rsp_tlast !== want.last_arc)
            report($sformatf("last_arc %b, expected %b", rsp_tlast, want.last_arc));
         if (rsp_tuser !== want.status)
            report($sformatf("status %0d, expected %0d", rsp_tuser, want.status));
      end
   endtask

   // Bytes are decoded before results are checked, so an arc queued at this
   // edge always lands behind the ones that can be checked at it.
   always @(posedge clock) begin
      if (reset) begin
         clear_identifier();
         expected_arcs.delete();
      end else begin
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_arc();
      end
      pending_arcs <= expected_arcs.size();
   end

endmodule

// ===== sim/tb_der_oid_arc_decoder.sv =====
// ----------------------------------------------------------------------------
// DER OID arc decoder testbench
// Feeds directed and random OID content streams into the arc decoder with
// random gaps on both sides, lets the checker compare every arc, and prints
// the verdict.
// ----------------------------------------------------------------------------
module tb_der_oid_arc_decoder;
   import doad_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 700;
   localparam int PHASE_COUNT    = 4;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic [7:0]              req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tready = 1'b0;
   logic                    req_tready;
   logic                    rsp_tvalid;
   logic [ARC_OUT_BITS-1:0] rsp_tdata;
   logic                    rsp_tlast;
   logic [1:0]              rsp_tuser;

   int error_count;
   int pending_arcs;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int bytes_sent     = 0;
   int rsp_stall_left = 0;
   int idle_cycles    = 0;

   der_oid_arc_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   der_oid_arc_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser),
      .error_count  (error_count),
      .pending_arcs (pending_arcs)
   );

   always #1 clock = ~clock;

   // No gap unless the idle draw hits; a gap is mostly short, now and then long.
   function automatic int pick_gap(input int idle_pct);
      if ($urandom_range(0, 99) >= idle_pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(6, 30);
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (rsp_stall_left == 0)
         rsp_stall_left = pick_gap(rsp_idle_pct);
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Returns at the edge where the byte is taken; tvalid stays high so the
   // next byte can follow without a bubble.
   task automatic send_byte(input logic [7:0] content, input logic eoc);
      int gap;
      gap = pick_gap(req_idle_pct);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(0, 255));
         req_tlast  <= 1'($urandom_range(0, 1));
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= content;
      req_tlast  <= eoc;
      do
         @(posedge clock);
      while (!req_tready);
      bytes_sent++;
   endtask

   // One identifier with random sub-identifiers; a few end inside a
   // sub-identifier, and some carry non-minimal leading zero groups.
   task automatic send_random_oid();
      int         subids;
      int         groups;
      int         pick;
      logic [6:0] bits;
      logic       truncate;
      logic       more;
      subids   = $urandom_range(1, 6);
      truncate = ($urandom_range(0, 11) == 0);
      for (int s = 0; s < subids; s++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            groups = 1;
         else if (pick < 75)
            groups = 2;
         else if (pick < 88)
            groups = 3;
         else if (pick < 95)
            groups = 4;
         else
            groups = $urandom_range(5, 6);
         if (truncate && s == subids - 1)
            groups = $urandom_range(1, 3);
         for (int g = 0; g < groups; g++) begin
            bits = 7'($urandom_range(0, 127));
            if (g == 0 && groups > 1 && $urandom_range(0, 7) == 0)
               bits = '0;
            more = (g != groups - 1) || (truncate && s == subids - 1);
            send_byte({more, bits}, s == subids - 1 && g == groups - 1);
         end
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_arcs != 0)
         @(negedge clock);
   endtask

   initial begin
      int start_count;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 20;
      rsp_idle_pct = 20;
      // Small first arcs, a two-byte arc, and the largest two-group arc.
      send_byte(8'h2A, 1'b0);
      send_byte(8'h86, 1'b0);
      send_byte(8'h48, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b1);
      // Identifier ending on a continuation byte.
      send_byte(8'h80, 1'b1);
      // Non-minimal first sub-identifier.
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      // Largest first sub-identifier that still fits, then a later one
      // that overflows.
      send_byte(8'h8F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b1);
      // Overflowing first sub-identifier.
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b1);

      // Hold the sender until every outstanding arc has come back.
      wait_drained();

      start_count = bytes_sent;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
            1: begin
               req_idle_pct = 25;
               rsp_idle_pct = 25;
            end
            2: begin
               req_idle_pct = 10;
               rsp_idle_pct = 60;
            end
            default: begin
               req_idle_pct = 60;
               rsp_idle_pct = 10;
            end
         endcase
         while (bytes_sent - start_count < (phase + 1) * RANDOM_BYTES / PHASE_COUNT) begin
            if ($urandom_range(0, 9) == 0)
               send_noise();
            else
               send_random_oid();
         end
      end

      wait_drained();
      repeat (5) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
design/doad_pkg.sv
design/der_oid_arc_decoder.sv
design/doad_checker.sv
sim/der_oid_arc_checker.sv
sim/tb_der_oid_arc_decoder.sv
